// File: sv/pcsst_pkg.sv
// Package for the perf counter signal slot table: sizes, codes, item types, event mapping.
package pcsst_pkg;

    localparam int NUM_SETS      = 8;
    localparam int SLOTS_PER_SET = 4;
    localparam int NUM_SLOTS     = NUM_SETS * SLOTS_PER_SET;
    localparam int CODE_W        = 8;
    localparam int DATA_W        = 32;
    localparam int LOAD_CNT      = (SLOTS_PER_SET < 4) ? SLOTS_PER_SET : 4;
    localparam int SET_W         = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int SLOT_W        = (SLOTS_PER_SET > 1) ? $clog2(SLOTS_PER_SET) : 1;
    localparam int IDX_W         = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    // operation kinds
    localparam logic [1:0] KIND_WATCH   = 2'd0;
    localparam logic [1:0] KIND_UNWATCH = 2'd1;
    localparam logic [1:0] KIND_QUERY   = 2'd2;
    localparam logic [1:0] KIND_LOAD    = 2'd3;

    // status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_NO_SPACE = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

    localparam logic [1:0] EVENT_NONE = 2'd0;

    // chipset numbers
    localparam logic [7:0] CHIP_50 = 8'h50;
    localparam logic [7:0] CHIP_84 = 8'h84;
    localparam logic [7:0] CHIP_86 = 8'h86;
    localparam logic [7:0] CHIP_98 = 8'h98;
    localparam logic [7:0] CHIP_A0 = 8'ha0;
    localparam logic [7:0] CHIP_AC = 8'hac;
    localparam logic [7:0] CHIP_A3 = 8'ha3;
    localparam logic [7:0] CHIP_A5 = 8'ha5;
    localparam logic [7:0] CHIP_A8 = 8'ha8;
    localparam logic [7:0] CHIP_RESET = CHIP_50;

    // signal codes, one row per chipset family, one column per real event
    localparam logic [CODE_W-1:0] CODE_TAB [4][3] = '{
        '{8'hc8, 8'hca, 8'hd2},
        '{8'hbd, 8'hbf, 8'hc7},
        '{8'hc9, 8'hcb, 8'h1c},
        '{8'hcb, 8'hcd, 8'hd5}
    };

    typedef struct packed {
        logic [1:0]        kind;
        logic [1:0]        event_id;
        logic [2:0]        load_set;
        logic [DATA_W-1:0] load_cycles;
        logic [DATA_W-1:0] load_count0;
        logic [DATA_W-1:0] load_count1;
        logic [DATA_W-1:0] load_count2;
        logic [DATA_W-1:0] load_count3;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        status;
        logic [1:0]        slot;
        logic [DATA_W-1:0] cycles_out;
        logic [DATA_W-1:0] value_out;
    } t_out_item;

    typedef struct packed {
        logic              ok;
        logic              set_one;
        logic [CODE_W-1:0] code;
    } t_map;

    // event -> (set, code); unknown chipset gives ok = 0 and code 0
    function automatic t_map map_event(input logic [7:0] chip, input logic [1:0] ev);
        t_map       m;
        logic [1:0] row;
        m.ok      = 1'b1;
        m.set_one = (ev != EVENT_NONE);
        m.code    = '0;
        row       = 2'd0;
        if (ev != EVENT_NONE) begin
            unique case (chip)
                CHIP_50: row = 2'd0;
                CHIP_84, CHIP_86, CHIP_98: row = 2'd1;
                CHIP_A0, CHIP_AC: row = 2'd2;
                CHIP_A3, CHIP_A5, CHIP_A8: row = 2'd3;
                default: m.ok = 1'b0;
            endcase
            if (m.ok) begin
                m.code = CODE_TAB[row][ev - 2'd1];
            end
        end
        return m;
    endfunction

endpackage

// File: sv/perf_counter_signal_slot_table.sv
// Top level of the perf counter signal slot table.
// The result strobe o_done is registered and goes high in the cycle after the accepting edge.
// Throughput: one item every cycle; o_busy stays low, since the slot compare of one
//   set runs in parallel from registers and the table updates at the accepting edge.
// Reset (i_rst_n low, synchronous): all slot codes empty, cycle counts and slot
//   values zero, chip_id back to 0x50. Results cannot be stalled by the receiver.
module perf_counter_signal_slot_table
    import pcsst_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  t_in_item    i_item,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    output logic        o_done,
    output t_out_item   o_result
);

    // table state
    logic [CODE_W-1:0] r_codes  [NUM_SLOTS];
    logic [DATA_W-1:0] r_counts [NUM_SLOTS];
    logic [DATA_W-1:0] r_cycles [NUM_SETS];
    logic [7:0]        r_chip_id;

    logic              r_done;
    t_out_item         r_result;

    // lookup for the mapped set
    t_map                  map;
    logic [SET_W-1:0]      map_set;
    logic [SLOTS_PER_SET-1:0] hit_eq;
    logic [SLOTS_PER_SET-1:0] hit_free;
    logic                  any_eq;
    logic                  any_free;
    logic [SLOT_W-1:0]     sel_eq;
    logic [SLOT_W-1:0]     sel_free;
    logic [IDX_W-1:0]      idx_eq;
    logic [IDX_W-1:0]      idx_free;
    logic                  load_ok;
    logic [SET_W-1:0]      load_set;
    logic [DATA_W-1:0]     load_cnt [4];

    // next values
    logic                  code_we;
    logic [IDX_W-1:0]      code_idx;
    logic [CODE_W-1:0]     code_wdata;
    t_out_item             n_result;

    assign o_busy   = 1'b0;
    assign o_done   = r_done;
    assign o_result = r_result;

    always_comb begin
        map     = map_event(r_chip_id, i_item.event_id);
        map_set = SET_W'(map.set_one);
        for (int i = 0; i < SLOTS_PER_SET; i++) begin
            hit_eq[i]   = (r_codes[IDX_W'(int'(map.set_one) * SLOTS_PER_SET + i)] == map.code);
            hit_free[i] = hit_eq[i] ||
                          (r_codes[IDX_W'(int'(map.set_one) * SLOTS_PER_SET + i)] == '0);
        end
        // first hit wins: scan from the top down
        sel_eq   = '0;
        sel_free = '0;
        for (int i = SLOTS_PER_SET - 1; i >= 0; i--) begin
            if (hit_eq[i]) begin
                sel_eq = SLOT_W'(i);
            end
            if (hit_free[i]) begin
                sel_free = SLOT_W'(i);
            end
        end
        any_eq   = |hit_eq;
        any_free = |hit_free;
        idx_eq   = IDX_W'(int'(map.set_one) * SLOTS_PER_SET + int'(sel_eq));
        idx_free = IDX_W'(int'(map.set_one) * SLOTS_PER_SET + int'(sel_free));

        load_ok  = (int'(i_item.load_set) < NUM_SETS);
        load_set = SET_W'(i_item.load_set);
        load_cnt[0] = i_item.load_count0;
        load_cnt[1] = i_item.load_count1;
        load_cnt[2] = i_item.load_count2;
        load_cnt[3] = i_item.load_count3;

        code_we    = 1'b0;
        code_idx   = idx_eq;
        code_wdata = map.code;
        n_result   = '{status: STATUS_NOT_FOUND, slot: 2'd0,
                       cycles_out: '0, value_out: '0};

        unique case (i_item.kind)
            KIND_WATCH: begin
                if (map.ok) begin
                    if (any_free) begin
                        code_we         = 1'b1;
                        code_idx        = idx_free;
                        n_result.status = STATUS_OK;
                        n_result.slot   = 2'(sel_free);
                    end else begin
                        n_result.status = STATUS_NO_SPACE;
                    end
                end
            end
            KIND_UNWATCH: begin
                if (map.ok && any_eq) begin
                    code_we         = 1'b1;
                    code_wdata      = '0;
                    n_result.status = STATUS_OK;
                    n_result.slot   = 2'(sel_eq);
                end
            end
            KIND_QUERY: begin
                // chipset error is not checked here: unknown chip looks up code 0
                if (any_eq) begin
                    n_result.status     = STATUS_OK;
                    n_result.slot       = 2'(sel_eq);
                    n_result.cycles_out = r_cycles[map_set];
                    n_result.value_out  = r_counts[idx_eq];
                end
            end
            KIND_LOAD: begin
                if (load_ok) begin
                    n_result.status = STATUS_OK;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chip_id <= CHIP_RESET;
            r_done    <= 1'b0;
            r_result  <= '0;
            for (int k = 0; k < NUM_SLOTS; k++) begin
                r_codes[k]  <= '0;
                r_counts[k] <= '0;
            end
            for (int s = 0; s < NUM_SETS; s++) begin
                r_cycles[s] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_chip_id <= i_cfg_wdata;
            end
            r_done <= i_start;
            if (i_start) begin
                r_result <= n_result;
                if (code_we) begin
                    r_codes[code_idx] <= code_wdata;
                end
                if (i_item.kind == KIND_LOAD && load_ok) begin
                    r_cycles[load_set] <= i_item.load_cycles;
                    for (int i = 0; i < LOAD_CNT; i++) begin
                        r_counts[IDX_W'(int'(load_set) * SLOTS_PER_SET + i)] <= load_cnt[i];
                    end
                end
            end
        end
    end

endmodule

// File: test/perf_counter_signal_slot_table_tb.sv
// Self-checking testbench for the perf counter signal slot table.
`timescale 1ns / 1ps

module perf_counter_signal_slot_table_tb;
    import pcsst_pkg::*;

    localparam int CLK_HALF        = 4;
    localparam int RESET_CYCLES    = 12;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int REPORT_MAX      = 10;
    localparam int NUM_PHASES      = 12;
    localparam int ITEMS_PER_PHASE = 146;

    // chip numbers with no entry in the signal code table
    localparam logic [7:0] CHIP_UNKNOWN_LO = 8'h00;
    localparam logic [7:0] CHIP_UNKNOWN_HI = 8'hff;

    // chip setting per random phase; the last one is replaced by a random number
    localparam logic [7:0] CHIP_PLAN [NUM_PHASES] = '{
        CHIP_50, CHIP_A0, CHIP_UNKNOWN_LO, CHIP_84, CHIP_A3, CHIP_86,
        CHIP_UNKNOWN_HI, CHIP_AC, CHIP_A5, CHIP_98, CHIP_A8, CHIP_RESET
    };

    // percent of cycles the sender sits idle, cycled over the random phases
    localparam int IDLE_PLAN [3] = '{0, 85, 25};

    // Tracks the slot table, the readouts and the chip setting, and holds the
    // results still owed by the block, oldest first.
    class slot_table_model;
        logic [7:0]        chip;
        logic [CODE_W-1:0] codes  [NUM_SLOTS];
        logic [DATA_W-1:0] cycles [NUM_SETS];
        logic [DATA_W-1:0] counts [NUM_SLOTS];
        t_out_item         owed [$];
        int                mismatches;

        function new();
            chip = CHIP_RESET;
            foreach (codes[k]) codes[k] = '0;
            foreach (counts[k]) counts[k] = '0;
            foreach (cycles[k]) cycles[k] = '0;
            mismatches = 0;
        endfunction

        function void report(string what, t_out_item want, t_out_item got);
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
                $display("%0t %s: expected st=%0d slot=%0d cyc=%h val=%h,",
                         $time, what, want.status, want.slot, want.cycles_out,
                         want.value_out);
                $display("    got st=%0d slot=%0d cyc=%h val=%h",
                         got.status, got.slot, got.cycles_out, got.value_out);
            end
        endfunction

        // Applies one accepted item and queues the result it should produce.
        function void accept_item(t_in_item it);
            t_out_item         r;
            logic              known;
            int                sel;
            int                fam;
            int                i;
            int                k;
            logic [CODE_W-1:0] code;
            logic [DATA_W-1:0] load_vals [4];

            r        = '0;
            r.status = STATUS_NOT_FOUND;
            known    = 1'b1;
            sel      = 0;
            fam      = 0;
            code     = '0;

            // none event: set 0, code 0, never an error; others land in set 1
            if (it.event_id != EVENT_NONE) begin
                sel = 1;
                case (chip)
                    CHIP_50:                   fam = 0;
                    CHIP_84, CHIP_86, CHIP_98: fam = 1;
                    CHIP_A0, CHIP_AC:          fam = 2;
                    CHIP_A3, CHIP_A5, CHIP_A8: fam = 3;
                    default:                   known = 1'b0;
                endcase
                if (known) code = CODE_TAB[fam][int'(it.event_id) - 1];
            end

            case (it.kind)
                KIND_WATCH: begin
                    if (known) begin
                        r.status = STATUS_NO_SPACE;
                        for (i = 0; i < SLOTS_PER_SET; i++) begin
                            k = sel * SLOTS_PER_SET + i;
                            if (codes[k] == '0 || codes[k] == code) begin
                                codes[k] = code;
                                r.status = STATUS_OK;
                                r.slot   = i[1:0];
                                break;
                            end
                        end
                    end
                end
                KIND_UNWATCH: begin
                    if (known) begin
                        for (i = 0; i < SLOTS_PER_SET; i++) begin
                            k = sel * SLOTS_PER_SET + i;
                            if (codes[k] == code) begin
                                codes[k] = '0;
                                r.status = STATUS_OK;
                                r.slot   = i[1:0];
                                break;
                            end
                        end
                    end
                end
                KIND_QUERY: begin
                    // the chipset error is not checked here: unknown gives code 0
                    for (i = 0; i < SLOTS_PER_SET; i++) begin
                        k = sel * SLOTS_PER_SET + i;
                        if (codes[k] == code) begin
                            r.status     = STATUS_OK;
                            r.slot       = i[1:0];
                            r.cycles_out = cycles[sel];
                            r.value_out  = counts[k];
                            break;
                        end
                    end
                end
                default: begin
                    load_vals = '{it.load_count0, it.load_count1,
                                  it.load_count2, it.load_count3};
                    if (int'(it.load_set) < NUM_SETS) begin
                        cycles[it.load_set] = it.load_cycles;
                        for (i = 0; i < LOAD_CNT; i++) begin
                            counts[int'(it.load_set) * SLOTS_PER_SET + i] = load_vals[i];
                        end
                        r.status = STATUS_OK;
                    end
                end
            endcase
            owed.push_back(r);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            logic      bad;

            if (owed.size() == 0) begin
                report("result with nothing expected", '0, got);
                return;
            end
            want = owed.pop_front();
            bad  = (got.status !== want.status) || (got.slot !== want.slot) ||
                   (got.cycles_out !== want.cycles_out) || (got.value_out !== want.value_out);
            if (bad) report("result mismatch", want, got);
        endfunction
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_start;
    logic      o_busy;
    t_in_item  i_item;
    logic      i_cfg_we;
    logic [7:0] i_cfg_wdata;
    logic      o_done;
    t_out_item o_result;

    slot_table_model model = new();
    int unsigned     cycle_count = 0;

    perf_counter_signal_slot_table uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_done      (o_done),
        .o_result    (o_result)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Monitor: check the result leaving at this edge before noting the item
    // entering at it, so the queue stays in order.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (o_done === 1'b1) model.check_result(o_result);
            if (i_start && !o_busy) model.accept_item(i_item);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL perf_counter_signal_slot_table");
            $finish;
        end
    end

    // Mostly random words, with the all-zero and all-one extremes now and then.
    function automatic logic [DATA_W-1:0] rand_word();
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick == 0) return '0;
        if (pick == 1) return '1;
        return $urandom();
    endfunction

    // Non-load items still carry random load fields; the block must ignore them.
    function automatic t_in_item make_item(logic [1:0] kind, logic [1:0] ev);
        t_in_item it;
        it.kind        = kind;
        it.event_id    = ev;
        it.load_set    = 3'($urandom_range(7));
        it.load_cycles = rand_word();
        it.load_count0 = rand_word();
        it.load_count1 = rand_word();
        it.load_count2 = rand_word();
        it.load_count3 = rand_word();
        return it;
    endfunction

    function automatic t_in_item load_item(logic [2:0] set_idx, logic [DATA_W-1:0] cyc,
                                           logic [DATA_W-1:0] c0, logic [DATA_W-1:0] c1,
                                           logic [DATA_W-1:0] c2, logic [DATA_W-1:0] c3);
        t_in_item it;
        it             = make_item(KIND_LOAD, EVENT_NONE);
        it.load_set    = set_idx;
        it.load_cycles = cyc;
        it.load_count0 = c0;
        it.load_count1 = c1;
        it.load_count2 = c2;
        it.load_count3 = c3;
        return it;
    endfunction

    // Random mix: watches outnumber unwatches so set 1 fills up across chip
    // families and the no-space path gets hit; loads aim mostly at sets 0 and 1,
    // which are the only ones a query can read.
    function automatic t_in_item random_item();
        t_in_item    it;
        int unsigned pick;
        logic [1:0]  kind;
        logic [1:0]  ev;

        pick = $urandom_range(99);
        if (pick < 32)      kind = KIND_WATCH;
        else if (pick < 54) kind = KIND_UNWATCH;
        else if (pick < 84) kind = KIND_QUERY;
        else                kind = KIND_LOAD;
        ev = ($urandom_range(99) < 15) ? EVENT_NONE : 2'($urandom_range(3, 1));
        it = make_item(kind, ev);
        if (kind == KIND_LOAD && $urandom_range(99) < 70) begin
            it.load_set = 3'($urandom_range(1));
        end
        return it;
    endfunction

    // Hold start low for random idle cycles, then present the item until taken.
    // Start stays high on return so back-to-back items need no extra edge.
    task automatic send_item(input t_in_item it, input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_item  <= it;
        do @(posedge i_clk); while (o_busy);
    endtask

    task automatic op(input logic [1:0] kind, input logic [1:0] ev);
        send_item(make_item(kind, ev), 0);
    endtask

    // Stop sending and wait until every owed result has come back.
    task automatic settle();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (model.owed.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_chip(input logic [7:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        model.chip  = value;
    endtask

    initial begin
        logic [7:0] chip;
        int         p;
        int         n;

        i_rst_n     = 1'b0;
        i_start     = 1'b0;
        i_item      = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed: reset chip, empty table ---
        write_chip(CHIP_50);
        op(KIND_QUERY, 2'd1);              // empty set 1: not found
        op(KIND_QUERY, EVENT_NONE);        // empty slot matches code 0
        send_item(load_item(3'd1, '1, '1, '0, 32'ha5a5a5a5, 32'h5a5a5a5a), 0);
        send_item(load_item(3'd0, 32'h12345678, 32'h0, 32'hffffffff, 32'h1, 32'h80000000), 0);
        op(KIND_WATCH, 2'd1);
        op(KIND_WATCH, 2'd2);
        op(KIND_WATCH, 2'd3);
        op(KIND_WATCH, 2'd1);              // already watched: same slot again
        op(KIND_QUERY, 2'd2);
        op(KIND_WATCH, EVENT_NONE);        // takes first empty slot, leaves it empty
        op(KIND_UNWATCH, EVENT_NONE);      // matches first empty slot
        op(KIND_QUERY, EVENT_NONE);
        op(KIND_UNWATCH, 2'd2);
        op(KIND_UNWATCH, 2'd2);            // gone already: not found
        op(KIND_WATCH, 2'd2);
        settle();

        // second chip family fills the last slot of set 1
        write_chip(CHIP_84);
        op(KIND_WATCH, 2'd1);
        op(KIND_WATCH, 2'd2);              // set 1 full: no space
        op(KIND_QUERY, 2'd3);
        settle();

        // unknown chip: watch and unwatch refused, query looks for code 0
        write_chip(CHIP_UNKNOWN_LO);
        op(KIND_WATCH, 2'd1);
        op(KIND_UNWATCH, 2'd1);
        op(KIND_QUERY, 2'd1);
        op(KIND_QUERY, EVENT_NONE);
        settle();

        write_chip(CHIP_UNKNOWN_HI);
        op(KIND_UNWATCH, EVENT_NONE);      // none event is never an error
        send_item(load_item(3'd7, '1, '1, '1, '1, '1), 0);
        settle();

        // --- random phases: new chip setting and sender idle rate per phase ---
        for (p = 0; p < NUM_PHASES; p++) begin
            chip = (p == NUM_PHASES - 1) ? 8'($urandom_range(255)) : CHIP_PLAN[p];
            write_chip(chip);
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                send_item(random_item(), IDLE_PLAN[p % 3]);
            end
            settle();
        end

        repeat (4) @(posedge i_clk);
        if (model.owed.size() != 0) begin
            $display("%0d expected results never arrived", model.owed.size());
        end
        if (model.mismatches == 0 && model.owed.size() == 0) begin
            $display("PASS perf_counter_signal_slot_table");
        end else begin
            $display("FAIL perf_counter_signal_slot_table");
        end
        $finish;
    end

endmodule

// File: filelist.f
sv/pcsst_pkg.sv
sv/perf_counter_signal_slot_table.sv
test/perf_counter_signal_slot_table_tb.sv
